[hw/rtl/spq_pkg.sv]
// package for the two-key sorted priority queue: types, constants and helpers
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CAPACITY   = 64;
	localparam int NAME_BYTES = 20;
	localparam int NAME_WORDS = 3;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	localparam logic [6:0] SCORE_MAX = 7'd100;

	// operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [63:0] name_word0;
		logic [63:0] name_word1;
		logic [63:0] name_word2;
		logic [6:0]  primary_score;
		logic [6:0]  secondary_score;
	} spq_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] out_name_word0;
		logic [63:0] out_name_word1;
		logic [63:0] out_name_word2;
		logic [6:0]  out_primary_score;
		logic [6:0]  out_secondary_score;
		logic [6:0]  occupancy;
	} spq_rsp_t;

	// one queue entry as held in a cell
	typedef struct packed {
		logic [NAME_WORDS-1:0][63:0] name;
		logic [6:0]                  pri;
		logic [6:0]                  sec;
	} spq_entry_t;

	// per-cell control from the top level
	typedef struct packed {
		logic enq;
		logic deq;
		logic occ;
	} spq_ctrl_t;

	function automatic logic [6:0] sat_score(input logic [6:0] v);
		sat_score = (v > SCORE_MAX) ? SCORE_MAX : v;
	endfunction

	// bytes at or beyond NAME_BYTES are cleared
	function automatic logic [63:0] name_mask(input int w);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (w * 8 + b < NAME_BYTES) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		name_mask = m;
	endfunction

endpackage

[hw/rtl/spq_cell.sv]
// one cell of the sorted shift chain: holds one entry
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  spq_ctrl_t  ctrl,
	input  spq_entry_t new_entry,
	input  spq_entry_t prev_entry,
	input  logic       prev_lt,
	input  spq_entry_t next_entry,
	output spq_entry_t entry,
	output logic       lt
);

	spq_entry_t entry_q;

	// occupied and strictly below the new key: stays in place on insert
	assign lt = ctrl.occ && ({entry_q.pri, entry_q.sec} < {new_entry.pri, new_entry.sec});

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			entry_q <= next_entry;
		end else if (ctrl.enq && !lt) begin
			entry_q <= prev_lt ? new_entry : prev_entry;
		end
	end

	assign entry = entry_q;

endmodule

[hw/rtl/two_key_sorted_priority_queue.sv]
// top level of the two-key sorted priority queue
//
// Usage: requests arrive on req (valid/stall); each request gives exactly one
// response on rsp (valid/stall). An enqueue inserts the entry in order of
// (primary_score, secondary_score), ahead of equal keys, or answers full.
// A dequeue returns the head entry (smallest key) or answers empty.
// Scores above 100 saturate; name bytes past NAME_BYTES are cleared.
// The response is registered and valid in the cycle after the transfer.
// Throughput: one request per cycle while req_stall is low; the whole chain
// of cells shifts or inserts in the cycle of the transfer, so the next
// request sees the result. Reset clears the entry count and the response
// valid flag; cells keep their contents and only occupied cells are ever read.
// When the receiver stalls, the response register holds and req_stall is
// raised until the response is taken; a waiting response may be taken in
// the same cycle as the next request transfers.
`timescale 1ns / 1ps

module two_key_sorted_priority_queue
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output spq_rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	spq_rsp_t         rsp_q;

	logic       req_xfer;
	logic       is_full;
	logic       is_empty;
	logic       do_enq;
	logic       do_deq;
	spq_rsp_t   rsp_d;
	spq_entry_t new_entry;
	spq_entry_t cells [CAPACITY];
	logic       lts   [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_xfer  = req_valid && !req_stall;
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign do_enq    = req_xfer && (req.operation == OP_ENQ) && !is_full;
	assign do_deq    = req_xfer && (req.operation == OP_DEQ) && !is_empty;

	always_comb begin
		new_entry.name[0] = req.name_word0 & name_mask(0);
		new_entry.name[1] = req.name_word1 & name_mask(1);
		new_entry.name[2] = req.name_word2 & name_mask(2);
		new_entry.pri     = sat_score(req.primary_score);
		new_entry.sec     = sat_score(req.secondary_score);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_ctrl_t  ctrl;
		spq_entry_t prev_e;
		spq_entry_t next_e;
		logic       prev_l;

		assign ctrl.enq = do_enq;
		assign ctrl.deq = do_deq;
		assign ctrl.occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_e = new_entry;
			assign prev_l = 1'b1;
		end else begin : g_rest
			assign prev_e = cells[i-1];
			assign prev_l = lts[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_e = cells[i];
		end else begin : g_mid
			assign next_e = cells[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_lt    (prev_l),
			.next_entry (next_e),
			.entry      (cells[i]),
			.lt         (lts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (do_enq) begin
				count_q <= count_q + 1'b1;
			end else if (do_deq) begin
				count_q <= count_q - 1'b1;
			end
			if (req_xfer) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_comb begin
		rsp_d = '0;
		if (req.operation == OP_ENQ) begin
			if (is_full) begin
				rsp_d.status    = ST_FULL;
				rsp_d.occupancy = 7'(count_q);
			end else begin
				rsp_d.status    = ST_OK;
				rsp_d.occupancy = 7'(count_q + 1'b1);
			end
		end else begin
			if (is_empty) begin
				rsp_d.status    = ST_EMPTY;
				rsp_d.occupancy = 7'(count_q);
			end else begin
				rsp_d.status              = ST_OK;
				rsp_d.out_name_word0      = cells[0].name[0];
				rsp_d.out_name_word1      = cells[0].name[1];
				rsp_d.out_name_word2      = cells[0].name[2];
				rsp_d.out_primary_score   = cells[0].pri;
				rsp_d.out_secondary_score = cells[0].sec;
				rsp_d.occupancy           = 7'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/spq_checker.sv]
// port-level assertions for the two-key sorted priority queue, bound to the top
`timescale 1ns / 1ps

module spq_checker
	import spq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input spq_req_t req,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input spq_rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// every request transfer yields a response in the next cycle
	a_req_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("no response after request transfer");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == 7'(CAPACITY))
		else $error("full reported below capacity");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |->
			rsp.occupancy == 7'd0 && rsp.out_name_word0 == '0 &&
			rsp.out_name_word1 == '0 && rsp.out_name_word2 == '0 &&
			rsp.out_primary_score == '0 && rsp.out_secondary_score == '0)
		else $error("empty response not clean");

	// stored scores are always saturated
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.out_primary_score <= SCORE_MAX &&
			rsp.out_secondary_score <= SCORE_MAX)
		else $error("dequeued score above range");

endmodule

bind two_key_sorted_priority_queue spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
